FILE: hw/rtl/rfb_pkg.sv
package rfb_pkg;

  // Configuration port geometry: eight registers, the widest is 16 bits.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_AW-1:0] CFG_BPP         = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BIG_ENDIAN  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_RED_MAX     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_GREEN_MAX   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_BLUE_MAX    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_RED_SHIFT   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_GREEN_SHIFT = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_BLUE_SHIFT  = 3'd7;

  // Register values after reset.
  localparam logic [2:0]  RST_BPP         = 3'd4;
  localparam logic [15:0] RST_CHAN_MAX    = 16'd255;
  localparam logic [4:0]  RST_RED_SHIFT   = 5'd16;
  localparam logic [4:0]  RST_GREEN_SHIFT = 5'd8;
  localparam logic [4:0]  RST_BLUE_SHIFT  = 5'd0;

  // Server message types.
  localparam logic [7:0] MSG_FB_UPDATE = 8'd0;
  localparam logic [7:0] MSG_CMAP      = 8'd1;
  localparam logic [7:0] MSG_BELL      = 8'd2;
  localparam logic [7:0] MSG_CUT_TEXT  = 8'd3;

  // Result kinds.
  localparam logic [1:0] EV_PIXEL = 2'd0;
  localparam logic [1:0] EV_BELL  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // Quotient bits of the channel scaler, one per divider step.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_TYPE,
    ST_FB_PAD,
    ST_COUNT,
    ST_XY,
    ST_WH,
    ST_ENC,
    ST_PIXEL,
    ST_CMAP_PAD,
    ST_CUT_PAD,
    ST_LEN,
    ST_SKIP,
    ST_DIVIDE,
    ST_HALT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic shift;
    logic wrap;
    logic load_count;
    logic load_xy;
    logic load_wh;
    logic load_skip;
    logic dec_skip;
    logic dec_rects;
    logic clear_pos;
    logic pix_byte;
    logic emit_bell;
    logic emit_error;
    logic emit_pixel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] in_byte;
    logic [2:0] bidx;
    logic       cnt16_zero;
    logic       w32_zero;
    logic       rect_empty;
    logic       rects_last;
    logic       fmt_bad;
    logic       pix_last;
    logic       col_last;
    logic       row_last;
    logic       skip_last;
    logic       div_busy;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/rfb_if.sv
// Byte stream channel.
interface rfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// Result channel.
interface rfb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [16:0] pixel_x;
  logic [16:0] pixel_y;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  modport source (output valid, output event_kind, output pixel_x, output pixel_y,
                  output red_out, output green_out, output blue_out, input ready);
  modport sink (input valid, input event_kind, input pixel_x, input pixel_y,
                input red_out, input green_out, input blue_out, output ready);
endinterface

FILE: hw/rtl/rfb_div.sv
module rfb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] numer,
  input  logic [15:0] chan_max,
  output logic        busy,
  output logic [7:0]  quotient
);
  import rfb_pkg::*;

  logic [DIV_CW-1:0] cnt;
  logic [16:0]       rem;
  logic [16:0]       dvs;
  logic [7:0]        quo;
  logic [17:0]       rem_sh;
  logic              fits;
  logic [16:0]       rem_next;

  // One restoring step: the numerator is numer*256, so each step shifts in a zero.
  always_comb begin
    rem_sh   = {rem, 1'b0};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? 17'(rem_sh - {1'b0, dvs}) : rem_sh[16:0];
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CW'(DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder, divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, numer};
      dvs <= {1'b0, chan_max} + 17'd1;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[6:0], fits};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = quo;
endmodule

FILE: hw/rtl/rfb_ctrl.sv
module rfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfb_pkg::dp_stat_t st,
  output rfb_pkg::dp_cmd_t  cmd
);
  import rfb_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;
  logic   acc;

  // State and return phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TYPE;
      ret   <= ST_TYPE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Message parser: one step per accepted word.
  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    in_ready   = (state != ST_DIVIDE) && st.out_free;
    acc        = in_valid && in_ready;

    if (acc) begin
      unique case (state)
        ST_TYPE: begin
          cmd.clear = 1'b1;
          if (st.in_byte == MSG_FB_UPDATE) begin
            state_next = ST_FB_PAD;
          end else if (st.in_byte == MSG_CMAP) begin
            state_next = ST_CMAP_PAD;
          end else if (st.in_byte == MSG_BELL) begin
            cmd.emit_bell = 1'b1;
          end else if (st.in_byte == MSG_CUT_TEXT) begin
            state_next = ST_CUT_PAD;
          end else begin
            cmd.emit_error = 1'b1;
            state_next     = ST_HALT;
          end
        end
        ST_FB_PAD: begin
          state_next = ST_COUNT;
        end
        ST_COUNT: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd1;
          if (cmd.wrap) begin
            cmd.load_count = 1'b1;
            state_next     = st.cnt16_zero ? ST_TYPE : ST_XY;
          end
        end
        ST_XY: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd3;
          if (cmd.wrap) begin
            cmd.load_xy = 1'b1;
            state_next  = ST_WH;
          end
        end
        ST_WH: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd3;
          if (cmd.wrap) begin
            cmd.load_wh = 1'b1;
            state_next  = ST_ENC;
          end
        end
        ST_ENC: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd3;
          if (cmd.wrap) begin
            if (!st.w32_zero) begin
              cmd.emit_error = 1'b1;
              state_next     = ST_HALT;
            end else if (st.rect_empty) begin
              cmd.clear_pos = 1'b1;
              cmd.dec_rects = 1'b1;
              state_next    = st.rects_last ? ST_TYPE : ST_XY;
            end else begin
              cmd.clear_pos = 1'b1;
              state_next    = ST_PIXEL;
            end
          end
        end
        ST_PIXEL: begin
          if (st.bidx == 3'd0 && st.fmt_bad) begin
            cmd.emit_error = 1'b1;
            state_next     = ST_HALT;
          end else begin
            cmd.pix_byte = 1'b1;
            if (st.pix_last) begin
              state_next = ST_DIVIDE;
              if (st.col_last && st.row_last) begin
                cmd.dec_rects = 1'b1;
                ret_next      = st.rects_last ? ST_TYPE : ST_XY;
              end else begin
                ret_next = ST_PIXEL;
              end
            end
          end
        end
        ST_CMAP_PAD: begin
          cmd.clear  = 1'b1;
          state_next = ST_LEN;
        end
        ST_CUT_PAD: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd2;
          if (cmd.wrap) begin
            state_next = ST_LEN;
          end
        end
        ST_LEN: begin
          cmd.shift = 1'b1;
          cmd.wrap  = st.bidx == 3'd3;
          if (cmd.wrap) begin
            cmd.load_skip = 1'b1;
            state_next    = st.w32_zero ? ST_TYPE : ST_SKIP;
          end
        end
        ST_SKIP: begin
          cmd.dec_skip = 1'b1;
          if (st.skip_last) begin
            state_next = ST_TYPE;
          end
        end
        ST_DIVIDE, ST_HALT: begin
        end
        default: begin
          state_next = ST_TYPE;
        end
      endcase
    end

    // Hand the scaled pixel to the output register once the dividers finish.
    if (state == ST_DIVIDE && !st.div_busy && st.out_free) begin
      cmd.emit_pixel = 1'b1;
      state_next     = ret;
    end
  end
endmodule

FILE: hw/rtl/rfb_dp.sv
module rfb_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 in_byte,
  input  logic                       cfg_we,
  input  logic [rfb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rfb_pkg::CFG_DW-1:0] cfg_data,
  input  rfb_pkg::dp_cmd_t           cmd,
  output rfb_pkg::dp_stat_t          st,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 event_kind,
  output logic [16:0]                pixel_x,
  output logic [16:0]                pixel_y,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out
);
  import rfb_pkg::*;

  logic [2:0]  bpp;
  logic        big_endian;
  logic [15:0] chan_max [3];
  logic [4:0]  chan_shift [3];

  logic [31:0] gw;
  logic [2:0]  bidx;
  logic [15:0] rects;
  logic [15:0] rect_left, rect_top, rect_width, rect_height;
  logic [15:0] col, row;
  logic [31:0] skip;
  logic [16:0] px, py;

  logic [31:0] gw_shift;
  logic [31:0] pix_word;
  logic        div_start;
  logic [2:0]  lane_busy;
  logic [7:0]  lane_q [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp           <= RST_BPP;
      big_endian    <= 1'b0;
      chan_max[0]   <= RST_CHAN_MAX;
      chan_max[1]   <= RST_CHAN_MAX;
      chan_max[2]   <= RST_CHAN_MAX;
      chan_shift[0] <= RST_RED_SHIFT;
      chan_shift[1] <= RST_GREEN_SHIFT;
      chan_shift[2] <= RST_BLUE_SHIFT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BPP:         bpp           <= cfg_data[2:0];
        CFG_BIG_ENDIAN:  big_endian    <= cfg_data[0];
        CFG_RED_MAX:     chan_max[0]   <= cfg_data;
        CFG_GREEN_MAX:   chan_max[1]   <= cfg_data;
        CFG_BLUE_MAX:    chan_max[2]   <= cfg_data;
        CFG_RED_SHIFT:   chan_shift[0] <= cfg_data[4:0];
        CFG_GREEN_SHIFT: chan_shift[1] <= cfg_data[4:0];
        CFG_BLUE_SHIFT:  chan_shift[2] <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Big-endian header gather and little-endian pixel gather.
  always_comb begin
    gw_shift = {gw[23:0], in_byte};
    pix_word = ((bidx == 3'd0) ? 32'd0 : gw) | ({24'd0, in_byte} << {bidx[1:0], 3'b000});
  end

  // Status for the controller.
  always_comb begin
    st.in_byte    = in_byte;
    st.bidx       = bidx;
    st.cnt16_zero = gw_shift[15:0] == 16'd0;
    st.w32_zero   = gw_shift == 32'd0;
    st.rect_empty = (rect_width == 16'd0) || (rect_height == 16'd0);
    st.rects_last = rects == 16'd1;
    st.fmt_bad    = ((bpp != 3'd2) && (bpp != 3'd4)) || big_endian;
    st.pix_last   = (({1'b0, bidx} + 4'd1) >= {1'b0, bpp}) || (bidx >= 3'd3);
    st.col_last   = ({1'b0, col} + 17'd1) >= {1'b0, rect_width};
    st.row_last   = ({1'b0, row} + 17'd1) >= {1'b0, rect_height};
    st.skip_last  = skip == 32'd1;
    st.div_busy   = |lane_busy;
    st.out_free   = !out_valid || out_ready;
  end

  assign div_start = cmd.pix_byte && st.pix_last;

  // Gather word and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      gw   <= '0;
      bidx <= '0;
    end else if (cmd.clear) begin
      gw   <= '0;
      bidx <= '0;
    end else if (cmd.shift) begin
      gw   <= cmd.wrap ? 32'd0 : gw_shift;
      bidx <= cmd.wrap ? 3'd0 : bidx + 3'd1;
    end else if (cmd.pix_byte) begin
      gw   <= st.pix_last ? 32'd0 : pix_word;
      bidx <= st.pix_last ? 3'd0 : bidx + 3'd1;
    end
  end

  // Rectangle header, counters and skip length.
  always_ff @(posedge clk) begin
    if (rst) begin
      rects       <= '0;
      rect_left   <= '0;
      rect_top    <= '0;
      rect_width  <= '0;
      rect_height <= '0;
      col         <= '0;
      row         <= '0;
      skip        <= '0;
    end else begin
      if (cmd.load_count) begin
        rects <= gw_shift[15:0];
      end else if (cmd.dec_rects) begin
        rects <= rects - 16'd1;
      end
      if (cmd.load_xy) begin
        rect_left <= gw_shift[31:16];
        rect_top  <= gw_shift[15:0];
      end
      if (cmd.load_wh) begin
        rect_width  <= gw_shift[31:16];
        rect_height <= gw_shift[15:0];
      end
      if (cmd.load_skip) begin
        skip <= gw_shift;
      end else if (cmd.dec_skip) begin
        skip <= skip - 32'd1;
      end
      if (cmd.clear_pos) begin
        col <= '0;
        row <= '0;
      end else if (div_start) begin
        if (st.col_last) begin
          col <= '0;
          row <= st.row_last ? 16'd0 : row + 16'd1;
        end else begin
          col <= col + 16'd1;
        end
      end
    end
  end

  // Pixel position, held while the channels are scaled.
  always_ff @(posedge clk) begin
    if (div_start) begin
      px <= {1'b0, rect_left} + {1'b0, col};
      py <= {1'b0, rect_top} + {1'b0, row};
    end
  end

  // One divider lane per channel: value*256/(max+1).
  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [31:0] shifted;
    logic [15:0] chan_val;

    always_comb begin
      shifted  = pix_word >> chan_shift[i];
      chan_val = shifted[15:0] & chan_max[i];
    end

    rfb_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .numer    (chan_val),
      .chan_max (chan_max[i]),
      .busy     (lane_busy[i]),
      .quotient (lane_q[i])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_bell || cmd.emit_error || cmd.emit_pixel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pixel) begin
      event_kind <= EV_PIXEL;
      pixel_x    <= px;
      pixel_y    <= py;
      red_out    <= lane_q[0];
      green_out  <= lane_q[1];
      blue_out   <= lane_q[2];
    end else if (cmd.emit_bell || cmd.emit_error) begin
      event_kind <= cmd.emit_error ? EV_ERROR : EV_BELL;
      pixel_x    <= '0;
      pixel_y    <= '0;
      red_out    <= '0;
      green_out  <= '0;
      blue_out   <= '0;
    end
  end
endmodule

FILE: hw/rtl/rfb_server_message_decoder.sv
// Channel      Dir   Words
// in_stream    in    stream_byte: one byte of the server message stream
// out_events   out   event_kind, pixel_x, pixel_y, red_out, green_out, blue_out
// cfg_*        in    register writes, index cfg_addr, data cfg_data
//
// Bytes that finish no pixel are taken one per cycle, back to back, while the
// output register is free. The last byte of a pixel starts 8 steps of the channel
// dividers, which run all three channels side by side; the pixel is emitted after.
// A bell or error result is loaded into the output register on its own byte.
// Reset is synchronous on rst; while a result waits in a stalled output register,
// no input byte is taken.
module rfb_server_message_decoder (
  input  logic                       clk,
  input  logic                       rst,
  rfb_in_if.sink                     in_stream,
  rfb_out_if.source                  out_events,
  input  logic                       cfg_we,
  input  logic [rfb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rfb_pkg::CFG_DW-1:0] cfg_data
);
  import rfb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     in_ready;

  assign in_stream.ready = in_ready;

  rfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rfb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_stream.stream_byte),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_events.valid),
    .out_ready  (out_events.ready),
    .event_kind (out_events.event_kind),
    .pixel_x    (out_events.pixel_x),
    .pixel_y    (out_events.pixel_y),
    .red_out    (out_events.red_out),
    .green_out  (out_events.green_out),
    .blue_out   (out_events.blue_out)
  );
endmodule

FILE: hw/rtl/rfb_checker.sv
module rfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [16:0] pixel_x,
  input logic [16:0] pixel_y,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out
);
  import rfb_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its word.
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(event_kind) && $stable(pixel_x)
      && $stable(pixel_y) && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("result word changed while stalled");

  // Bells and errors carry no position or color.
  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_PIXEL |-> pixel_x == 17'd0 && pixel_y == 17'd0
      && red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("bell or error carries data");

  // After an error is delivered the decoder stays silent.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && event_kind == EV_ERROR |=> !out_valid)
    else $error("result after protocol error");
endmodule

bind rfb_server_message_decoder rfb_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_events.valid),
  .out_ready  (out_events.ready),
  .event_kind (out_events.event_kind),
  .pixel_x    (out_events.pixel_x),
  .pixel_y    (out_events.pixel_y),
  .red_out    (out_events.red_out),
  .green_out  (out_events.green_out),
  .blue_out   (out_events.blue_out)
);

FILE: verif/tb_rfb_server_message_decoder.sv
`timescale 1ns / 1ps

module tb_rfb_server_message_decoder;
  import rfb_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] x;
    logic [16:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  rfb_in_if  in_stream ();
  rfb_out_if out_events ();

  rfb_server_message_decoder i_dut (
    .clk(clk), .rst(rst), .in_stream(in_stream.sink), .out_events(out_events.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the decoder registers and parser state.
  logic [2:0]  m_bpp;
  logic        m_big;
  logic [15:0] m_max [3];
  logic [4:0]  m_shift [3];
  state_t      m_phase;
  int unsigned m_bidx, m_word, m_rects, m_left, m_top, m_w, m_h, m_row, m_col, m_skip;
  bit          m_halted;

  event_t events_due [$];
  int errors = 0;
  int bytes_sent = 0;
  int events_seen = 0;
  int pixels_seen = 0;
  bit gaps_on = 1'b0;
  int stall_left = 0;

  function automatic logic [7:0] scale_chan(int unsigned v, logic [4:0] sh, logic [15:0] mx);
    int unsigned c;
    c = (v >> sh) & mx;
    return 8'((c * 256) / (int'(mx) + 1));
  endfunction

  function automatic void push_event(logic [1:0] k, int unsigned x, int unsigned y,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] b);
    event_t e;
    e.kind = k; e.x = 17'(x); e.y = 17'(y); e.r = r; e.g = g; e.b = b;
    events_due.push_back(e);
  endfunction

  function automatic void raise_error();
    m_halted = 1'b1;
    push_event(EV_ERROR, 0, 0, 0, 0, 0);
  endfunction

  // Gathers a big-endian word; returns 1 on its last byte.
  function automatic bit gather_be(logic [7:0] b, int unsigned n);
    m_word = (m_word << 8) | b;
    m_bidx++;
    if (m_bidx >= n) begin
      m_bidx = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void next_rect();
    m_rects = (m_rects - 1) & 16'hFFFF;
    m_phase = (m_rects == 0) ? ST_TYPE : ST_XY;
  endfunction

  // Advances the shadow parser by one accepted byte.
  function automatic void decode_byte(logic [7:0] b);
    if (m_halted) return;
    case (m_phase)
      ST_TYPE: begin
        m_bidx = 0; m_word = 0;
        if (b == MSG_FB_UPDATE) m_phase = ST_FB_PAD;
        else if (b == MSG_CMAP) m_phase = ST_CMAP_PAD;
        else if (b == MSG_BELL) push_event(EV_BELL, 0, 0, 0, 0, 0);
        else if (b == MSG_CUT_TEXT) m_phase = ST_CUT_PAD;
        else raise_error();
      end
      ST_FB_PAD: m_phase = ST_COUNT;
      ST_COUNT: if (gather_be(b, 2)) begin
        m_rects = m_word & 16'hFFFF; m_word = 0;
        m_phase = (m_rects == 0) ? ST_TYPE : ST_XY;
      end
      ST_XY: if (gather_be(b, 4)) begin
        m_left = m_word >> 16; m_top = m_word & 16'hFFFF; m_word = 0;
        m_phase = ST_WH;
      end
      ST_WH: if (gather_be(b, 4)) begin
        m_w = m_word >> 16; m_h = m_word & 16'hFFFF; m_word = 0;
        m_phase = ST_ENC;
      end
      ST_ENC: if (gather_be(b, 4)) begin
        if (m_word != 0) begin
          m_word = 0;
          raise_error();
        end else begin
          m_row = 0; m_col = 0;
          if (m_w == 0 || m_h == 0) next_rect();
          else m_phase = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (m_bidx == 0) begin
          if ((m_bpp != 2 && m_bpp != 4) || m_big) begin
            raise_error();
            return;
          end
          m_word = 0;
        end
        m_word |= int'(b) << (8 * (m_bidx & 3));
        m_bidx++;
        if (m_bidx < m_bpp && m_bidx < 4) return;
        m_bidx = 0;
        push_event(EV_PIXEL, m_left + m_col, m_top + m_row,
                   scale_chan(m_word, m_shift[0], m_max[0]),
                   scale_chan(m_word, m_shift[1], m_max[1]),
                   scale_chan(m_word, m_shift[2], m_max[2]));
        m_word = 0;
        m_col++;
        if (m_col >= m_w) begin
          m_col = 0;
          m_row++;
          if (m_row >= m_h) begin
            m_row = 0;
            next_rect();
          end
        end
      end
      ST_CMAP_PAD: begin
        m_phase = ST_LEN; m_bidx = 0; m_word = 0;
      end
      ST_CUT_PAD: begin
        m_bidx++;
        if (m_bidx >= 3) begin
          m_bidx = 0; m_word = 0; m_phase = ST_LEN;
        end
      end
      ST_LEN: if (gather_be(b, 4)) begin
        m_skip = m_word; m_word = 0;
        m_phase = (m_skip == 0) ? ST_TYPE : ST_SKIP;
      end
      ST_SKIP: begin
        m_skip--;
        if (m_skip == 0) m_phase = ST_TYPE;
      end
      default: begin
        m_phase = ST_TYPE; m_bidx = 0;
      end
    endcase
  endfunction

  // Sends one stream byte, with an optional gap before it.
  task automatic send_byte(logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_stream.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_stream.valid = 1'b1;
    in_stream.stream_byte = b;
    do @(posedge clk); while (!in_stream.ready);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word16(int unsigned v);
    send_byte(8'(v >> 8));
    send_byte(8'(v));
  endtask

  task automatic send_word32(int unsigned v);
    send_word16(v >> 16);
    send_word16(v);
  endtask

  // Waits until every expected result has come and the block has gone quiet.
  task automatic drain();
    in_stream.valid = 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned v);
    cfg_we = 1'b1; cfg_addr = idx; cfg_data = 16'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_BPP:         m_bpp = 3'(v);
      CFG_BIG_ENDIAN:  m_big = v[0];
      CFG_RED_MAX:     m_max[0] = 16'(v);
      CFG_GREEN_MAX:   m_max[1] = 16'(v);
      CFG_BLUE_MAX:    m_max[2] = 16'(v);
      CFG_RED_SHIFT:   m_shift[0] = 5'(v);
      CFG_GREEN_SHIFT: m_shift[1] = 5'(v);
      default:         m_shift[2] = 5'(v);
    endcase
  endtask

  task automatic set_format(int unsigned bpp, int unsigned rm, int unsigned gm,
                            int unsigned bm, int unsigned rs, int unsigned gs,
                            int unsigned bs);
    write_reg(CFG_BPP, bpp);
    write_reg(CFG_BIG_ENDIAN, 0);
    write_reg(CFG_RED_MAX, rm);
    write_reg(CFG_GREEN_MAX, gm);
    write_reg(CFG_BLUE_MAX, bm);
    write_reg(CFG_RED_SHIFT, rs);
    write_reg(CFG_GREEN_SHIFT, gs);
    write_reg(CFG_BLUE_SHIFT, bs);
  endtask

  function automatic int unsigned pick_max();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hFFFF;
      2: return 255;
      3: return 31;
      4: return 63;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_format();
    set_format($urandom_range(0, 1) ? 4 : 2, pick_max(), pick_max(), pick_max(),
               $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
  endtask

  // One rectangle header with raw encoding and its pixel bytes.
  task automatic send_rect(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
    send_word16(x); send_word16(y);
    send_word16(w); send_word16(h);
    send_word32(0);
    repeat (w * h * m_bpp) send_byte(8'($urandom));
  endtask

  task automatic send_update(int unsigned nrects, bit edge_pos);
    send_byte(MSG_FB_UPDATE);
    send_byte(8'($urandom));
    send_word16(nrects);
    repeat (nrects) begin
      if (edge_pos)
        send_rect($urandom_range(0, 1) ? 16'hFFFF : 0, $urandom_range(0, 1) ? 16'hFFFF : 0,
                  $urandom_range(0, 3), $urandom_range(0, 3));
      else
        send_rect($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 3), $urandom_range(0, 2));
    end
  endtask

  task automatic send_skipped(logic [7:0] kind, int unsigned len);
    send_byte(kind);
    repeat (kind == MSG_CMAP ? 1 : 3) send_byte(8'($urandom));
    send_word32(len);
    repeat (len) send_byte(8'($urandom));
  endtask

  // Directed: extremes of position and format, empty cases, every message type.
  task automatic test_directed();
    send_byte(MSG_BELL);
    send_update(0, 1'b0);
    send_update(2, 1'b1);
    send_skipped(MSG_CMAP, 0);
    send_skipped(MSG_CUT_TEXT, 0);
    send_skipped(MSG_CMAP, 3);
    send_skipped(MSG_CUT_TEXT, 2);
    drain();
    set_format(2, 16'hFFFF, 0, 31, 31, 0, 11);
    send_update(1, 1'b0);
    send_byte(MSG_BELL);
    drain();
  endtask

  // A size change in the middle of a pixel, made while no result is pending.
  task automatic test_size_change();
    set_format(4, 255, 255, 255, 16, 8, 0);
    send_byte(MSG_FB_UPDATE); send_byte(8'h00); send_word16(1);
    send_word16(10); send_word16(20); send_word16(2); send_word16(1);
    send_word32(0);
    repeat (3) send_byte(8'($urandom));
    drain();
    write_reg(CFG_BPP, 2);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    drain();
    write_reg(CFG_BPP, 4);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    drain();
  endtask

  // Random well-formed message streams under changing formats.
  task automatic test_random(int unsigned n_bytes);
    while (bytes_sent < n_bytes) begin
      if ($urandom_range(0, 7) == 0) begin
        drain();
        random_format();
      end
      case ($urandom_range(0, 9))
        0, 1:    send_byte(MSG_BELL);
        2:       send_skipped(MSG_CMAP, $urandom_range(0, 6));
        3:       send_skipped(MSG_CUT_TEXT, $urandom_range(0, 6));
        default: send_update($urandom_range(0, 3), $urandom_range(0, 3) == 0);
      endcase
    end
    drain();
  endtask

  // One fatal protocol error ends the stream, since the block halts until reset.
  task automatic test_error();
    case ($urandom_range(0, 3))
      0: send_byte(8'($urandom_range(4, 255)));
      1: begin
        send_byte(MSG_FB_UPDATE); send_byte(8'h00); send_word16(1);
        send_word32($urandom); send_word32($urandom);
        send_word32($urandom_range(1, 32'hFFFF_FFFF));
      end
      2: begin
        write_reg(CFG_BPP, 3);
        send_update(1, 1'b0);
        send_rect(0, 0, 1, 1);
      end
      default: begin
        write_reg(CFG_BIG_ENDIAN, 1);
        send_byte(MSG_FB_UPDATE); send_byte(8'h00); send_word16(1);
        send_rect(5, 5, 1, 1);
      end
    endcase
    drain();
  endtask

  // Result side: random stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_events.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_events.ready <= 1'b0;
    end else begin
      out_events.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_events.valid && out_events.ready) begin
      event_t e;
      events_seen++;
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d", $time, out_events.event_kind);
      end else begin
        e = events_due.pop_front();
        if (e.kind == EV_PIXEL) pixels_seen++;
        if (out_events.event_kind !== e.kind) begin
          errors++;
          $display("%0t: event_kind expected %0d actual %0d", $time, e.kind,
                   out_events.event_kind);
        end
        if (out_events.pixel_x !== e.x) begin
          errors++;
          $display("%0t: pixel_x expected %0d actual %0d", $time, e.x, out_events.pixel_x);
        end
        if (out_events.pixel_y !== e.y) begin
          errors++;
          $display("%0t: pixel_y expected %0d actual %0d", $time, e.y, out_events.pixel_y);
        end
        if (out_events.red_out !== e.r) begin
          errors++;
          $display("%0t: red_out expected %0d actual %0d", $time, e.r, out_events.red_out);
        end
        if (out_events.green_out !== e.g) begin
          errors++;
          $display("%0t: green_out expected %0d actual %0d", $time, e.g,
                   out_events.green_out);
        end
        if (out_events.blue_out !== e.b) begin
          errors++;
          $display("%0t: blue_out expected %0d actual %0d", $time, e.b, out_events.blue_out);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_stream.valid && in_stream.ready) || (out_events.valid && out_events.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, events_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_stream.valid = 1'b0;
    in_stream.stream_byte = '0;
    m_bpp = RST_BPP; m_big = 1'b0;
    m_max[0] = RST_CHAN_MAX; m_max[1] = RST_CHAN_MAX; m_max[2] = RST_CHAN_MAX;
    m_shift[0] = RST_RED_SHIFT; m_shift[1] = RST_GREEN_SHIFT; m_shift[2] = RST_BLUE_SHIFT;
    m_phase = ST_TYPE;
    m_bidx = 0; m_word = 0; m_rects = 0; m_left = 0; m_top = 0; m_w = 0; m_h = 0;
    m_row = 0; m_col = 0; m_skip = 0; m_halted = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    gaps_on = 1'b1;
    test_directed();
    test_size_change();
    test_random(560);
    gaps_on = 1'b0;
    test_random(700);
    test_error();
    $display("Sent %0d stream bytes; checked %0d results, %0d of them pixels.",
             bytes_sent, events_seen, pixels_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rfb_pkg.sv
hw/rtl/rfb_if.sv
hw/rtl/rfb_div.sv
hw/rtl/rfb_ctrl.sv
hw/rtl/rfb_dp.sv
hw/rtl/rfb_server_message_decoder.sv
hw/rtl/rfb_checker.sv
verif/tb_rfb_server_message_decoder.sv
